@@ hw/rtl/sorted_mode_finder_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SORTED_MODE_FINDER_TOP_DEFINES_SVH
`define SORTED_MODE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define SMF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_mode_finder: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_mode_finder: next-cycle check failed");

`endif

@@ hw/rtl/smf_pkg.sv @@
package smf_pkg;

    localparam int MAX_ITEMS   = 256;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W       = 16;
    localparam int MCNT_W      = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int PAD_W       = OUT_TDATA_W - VAL_W - MCNT_W;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] val;
        logic                    gt;   // holds a value above the incoming one, or empty
    } t_link;

    localparam t_link LINK_NONE = '{vld: 1'b0, val: '0, gt: 1'b0};

    typedef struct packed {
        logic ins;
        logic shift;
    } t_chain_ctl;

    typedef struct packed {
        logic step;
        logic first;
    } t_scan_ctl;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

@@ hw/rtl/smf_cell.sv @@
module smf_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smf_pkg::t_chain_ctl               i_ctl,
    input  logic signed [smf_pkg::VAL_W-1:0]  i_new,
    input  smf_pkg::t_link                    i_left,
    input  smf_pkg::t_link                    i_right,
    output smf_pkg::t_link                    o_link
);

    logic                             r_vld;
    logic signed [smf_pkg::VAL_W-1:0] r_val;
    logic                             n_vld;
    logic signed [smf_pkg::VAL_W-1:0] n_val;
    logic                             w_gt;

    assign w_gt = !r_vld || (r_val > i_new);

    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        if (i_ctl.ins && w_gt) begin
            // left neighbor also larger: shift right, else the new value lands here
            if (i_left.gt) begin
                n_vld = i_left.vld;
                n_val = i_left.val;
            end else begin
                n_vld = 1'b1;
                n_val = i_new;
            end
        end else if (i_ctl.shift) begin
            n_vld = i_right.vld;
            n_val = i_right.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link = '{vld: r_vld, val: r_val, gt: w_gt};

endmodule

@@ hw/rtl/smf_chain.sv @@
module smf_chain (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smf_pkg::t_chain_ctl               i_ctl,
    input  logic signed [smf_pkg::VAL_W-1:0]  i_new,
    output smf_pkg::t_link                    o_head
);

    smf_pkg::t_link w_link [smf_pkg::MAX_ITEMS];

    for (genvar g = 0; g < smf_pkg::MAX_ITEMS; g++) begin : g_cell
        smf_pkg::t_link w_left;
        smf_pkg::t_link w_right;

        if (g == 0) begin : g_head
            assign w_left = smf_pkg::LINK_NONE;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == smf_pkg::MAX_ITEMS - 1) begin : g_tail
            assign w_right = smf_pkg::LINK_NONE;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        smf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_new   (i_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    assign o_head = w_link[0];

endmodule

@@ hw/rtl/smf_scan.sv @@
module smf_scan (
    input  logic                              i_clk,
    input  smf_pkg::t_scan_ctl                i_ctl,
    input  logic signed [smf_pkg::VAL_W-1:0]  i_val,
    output logic signed [smf_pkg::VAL_W-1:0]  o_best,
    output logic [smf_pkg::CNT_W-1:0]         o_best_run
);

    logic signed [smf_pkg::VAL_W-1:0] r_prev;
    logic signed [smf_pkg::VAL_W-1:0] r_best;
    logic [smf_pkg::CNT_W-1:0]        r_run;
    logic [smf_pkg::CNT_W-1:0]        r_best_run;
    logic signed [smf_pkg::VAL_W-1:0] n_best;
    logic [smf_pkg::CNT_W-1:0]        n_run;
    logic [smf_pkg::CNT_W-1:0]        n_best_run;

    always_comb begin
        if (i_ctl.first) begin
            n_run      = smf_pkg::CNT_W'(1);
            n_best     = i_val;
            n_best_run = smf_pkg::CNT_W'(1);
        end else begin
            n_run      = (i_val == r_prev) ? r_run + smf_pkg::CNT_W'(1)
                                           : smf_pkg::CNT_W'(1);
            n_best     = r_best;
            n_best_run = r_best_run;
            // strictly longer only, so the smallest value keeps a tie
            if (n_run > r_best_run) begin
                n_best     = i_val;
                n_best_run = n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_prev     <= i_val;
            r_run      <= n_run;
            r_best     <= n_best;
            r_best_run <= n_best_run;
        end
    end

    assign o_best     = n_best;
    assign o_best_run = n_best_run;

endmodule

@@ hw/rtl/sorted_mode_finder_top.sv @@
// Mode of a set of signed 16-bit values.
// Input stream: one value per beat in s_axis_tdata[15:0]; s_axis_tlast marks
// the final value of a set. Up to 256 values are kept; later ones are dropped
// and flagged. Output stream: one beat per set with the mode (smallest value on
// ties), its count and the overflow flag.
// While loading, s_axis_tready stays high and each value is inserted in sorted
// position into a row of 256 compare cells in the cycle it is accepted.
// After the last beat s_axis_tready drops and the row shifts out one value per
// cycle into the run scanner (only the final value can be held, see below), one
// step for each value kept (1 to 256), and the result then goes to the output
// register. The scan also empties the row for the next set.
// The result sits in an output register; loading of the next set goes on while
// it waits. If the receiver stalls until the next scan ends, that scan holds
// on its final value until the register is free.
// Reset (synchronous, active low) empties the row, clears the count and the
// overflow flag and drops any pending result.
module sorted_mode_finder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [smf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [15:0] sample_value
    input  logic                                s_axis_tlast,   // is_last
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [smf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [15:0] mode_value,
                                                                // [24:16] mode_count, zero pad
    output logic                                m_axis_tuser    // overflowed
);

    smf_pkg::t_state                  r_state, n_state;
    logic [smf_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [smf_pkg::CNT_W-1:0]        r_left, n_left;
    logic                             r_first, n_first;
    logic                             r_ovf, n_ovf;
    logic                             r_out_vld, n_out_vld;
    logic [smf_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic                             r_out_user;

    logic                             w_accept;
    logic                             w_room;
    logic                             w_last_step;
    logic                             w_load_out;
    smf_pkg::t_chain_ctl              w_chain_ctl;
    smf_pkg::t_scan_ctl               w_scan_ctl;
    smf_pkg::t_link                   w_head;
    logic signed [smf_pkg::VAL_W-1:0] w_new;
    logic signed [smf_pkg::VAL_W-1:0] w_best;
    logic [smf_pkg::CNT_W-1:0]        w_best_run;

    assign s_axis_tready = (r_state == smf_pkg::ST_LOAD);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_room        = (r_cnt < smf_pkg::CNT_W'(smf_pkg::MAX_ITEMS));
    assign w_last_step   = (r_left == smf_pkg::CNT_W'(1));
    assign w_new         = $signed(s_axis_tdata[smf_pkg::VAL_W-1:0]);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_first     = r_first;
        n_ovf       = r_ovf;
        w_chain_ctl = '{ins: 1'b0, shift: 1'b0};
        w_scan_ctl  = '{step: 1'b0, first: r_first};
        w_load_out  = 1'b0;
        case (r_state)
            smf_pkg::ST_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        w_chain_ctl.ins = 1'b1;
                        n_cnt           = r_cnt + smf_pkg::CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = smf_pkg::ST_SCAN;
                        n_left  = w_room ? r_cnt + smf_pkg::CNT_W'(1) : r_cnt;
                        n_first = 1'b1;
                    end
                end
            end
            smf_pkg::ST_SCAN: begin
                // hold the final step until the output register can take it
                if (!w_last_step || !r_out_vld || m_axis_tready) begin
                    w_chain_ctl.shift = 1'b1;
                    w_scan_ctl.step   = 1'b1;
                    n_left            = r_left - smf_pkg::CNT_W'(1);
                    n_first           = 1'b0;
                    if (w_last_step) begin
                        w_load_out = 1'b1;
                        n_state    = smf_pkg::ST_LOAD;
                        n_cnt      = '0;
                        n_ovf      = 1'b0;
                    end
                end
            end
            default: begin
                n_state = smf_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        if (w_load_out) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= smf_pkg::ST_LOAD;
            r_cnt     <= '0;
            r_left    <= '0;
            r_first   <= 1'b0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_first   <= n_first;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {{smf_pkg::PAD_W{1'b0}},
                           smf_pkg::MCNT_W'(w_best_run),
                           w_best};
            r_out_user <= r_ovf;
        end
    end

    smf_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_chain_ctl),
        .i_new   (w_new),
        .o_head  (w_head)
    );

    smf_scan u_scan (
        .i_clk      (i_clk),
        .i_ctl      (w_scan_ctl),
        .i_val      (w_head.val),
        .o_best     (w_best),
        .o_best_run (w_best_run)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

@@ hw/rtl/smf_checker.sv @@
`include "sorted_mode_finder_top_defines.svh"

module smf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_s_tlast,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [smf_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input logic                            i_m_tuser
);

    logic w_m_stall;
    logic w_last_beat;

    assign w_m_stall   = i_m_tvalid && !i_m_tready;
    assign w_last_beat = i_s_tvalid && i_s_tready && i_s_tlast;

    `SMF_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, w_m_stall, i_m_tvalid)
    `SMF_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, w_m_stall,
        $stable(i_m_tdata) && $stable(i_m_tuser))
    `SMF_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, w_last_beat, !i_s_tready)
    `SMF_ASSERT_SAME(a_count_nonzero, i_clk, i_rst_n, i_m_tvalid,
        i_m_tdata[24:16] != 9'd0)
    `SMF_ASSERT_SAME(a_result_after_scan, i_clk, i_rst_n, $rose(i_m_tvalid),
        $past(!i_s_tready))

endmodule

bind sorted_mode_finder_top smf_checker u_smf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tlast  (s_axis_tlast),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
